/* design/i2a_pkg.sv */
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int IN_TDATA_W     = 64;
  localparam int IN_TUSER_W     = 5;
  localparam int OUT_TDATA_W    = 8;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HXL = 2'd2,
    RADIX_HXU = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    SIZE_NORMAL = 2'd0,
    SIZE_SHORT  = 2'd1,
    SIZE_FULL   = 2'd2,
    SIZE_SPARE  = 2'd3
  } size_t;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  // Map one digit to its ASCII character, letters in either case.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    begin
      if (d < 4'd10) begin
        c = CH_ZERO + {4'd0, d};
      end else if (upper) begin
        c = CH_UPPER_A + {4'd0, d} - 8'd10;
      end else begin
        c = CH_LOWER_A + {4'd0, d} - 8'd10;
      end
      return c;
    end
  endfunction

endpackage

/* design/integer_to_ascii_radix_core.sv */
`timescale 1ns / 1ps
// Operation: a word loads on its accepting edge; decimal then runs the bit-serial shift-add-3
// binary to BCD loop, and leading zero digits are dropped before the first character is valid.
// Flow: one word at a time; in_tready is high only in idle, so a new word is not accepted until
// the last character of the previous one is registered for output. Octal and hex load straight
// into the digit shift register, and may emit prefix characters ahead of their digits.
// Reset: rst_n is synchronous, active low; clears the state machine and the output valid.
module integer_to_ascii_radix_core #(
  parameter int DATA_WIDTH = i2a_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2a_pkg::IN_TDATA_W-1:0]      in_tdata,   // [63:0] value
  input  logic [i2a_pkg::IN_TUSER_W-1:0]      in_tuser,   // [1:0] op, [3:2] size_mode,
                                                          // [4] alternate_form
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [i2a_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] character
  output logic                                out_tlast
);

  localparam int NDIG  = (DATA_WIDTH + 2) / 3;
  localparam int DIG_W = 4 * NDIG;
  localparam int OCT_W = 3 * NDIG;
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int REM_W = $clog2(NDIG + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CONV = 6'b000010,
    ST_SKIP = 6'b000100,
    ST_PRE0 = 6'b001000,
    ST_PRE1 = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [DATA_WIDTH-1:0]       bin_r, bin_nxt;
  logic [DIG_W-1:0]            dig_r, dig_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  i2a_pkg::radix_t             op_r, op_nxt;
  logic                        alt_r, alt_nxt;
  logic                        zero_r, zero_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_fire;
  logic                        slot_free;
  logic [DATA_WIDTH-1:0]       in_val;
  i2a_pkg::radix_t             in_op;
  i2a_pkg::size_t              in_size;
  logic [DIG_W-1:0]            hex_ext;
  logic [OCT_W-1:0]            oct_ext;
  logic [DIG_W-1:0]            load_dig;
  logic [DIG_W-1:0]            dabble;
  logic [3:0]                  top_dig;
  logic                        has_prefix;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign in_op      = i2a_pkg::radix_t'(in_tuser[1:0]);
  assign in_size    = i2a_pkg::size_t'(in_tuser[3:2]);
  assign top_dig    = dig_r[DIG_W-1 -: 4];
  assign has_prefix = alt_r && !zero_r && (op_r != i2a_pkg::RADIX_DEC);

  // Size truncation, bit by bit.
  always_comb begin
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (in_size == i2a_pkg::SIZE_SHORT) begin
        in_val[i] = (i < 16) ? in_tdata[i] : 1'b0;
      end else if (in_size == i2a_pkg::SIZE_NORMAL) begin
        in_val[i] = (i < 32) ? in_tdata[i] : 1'b0;
      end else begin
        in_val[i] = in_tdata[i];
      end
    end
  end

  assign hex_ext = DIG_W'(in_val);
  assign oct_ext = OCT_W'(in_val);

  // Octal and hex digits are straight bit groups: drop them into the digit slots.
  always_comb begin
    for (int g = 0; g < NDIG; g++) begin
      if (in_op == i2a_pkg::RADIX_OCT) begin
        load_dig[4*g +: 4] = {1'b0, oct_ext[3*g +: 3]};
      end else begin
        load_dig[4*g +: 4] = hex_ext[4*g +: 4];
      end
    end
  end

  // Add 3 to every BCD digit of five or more, ahead of the shift.
  always_comb begin
    for (int g = 0; g < NDIG; g++) begin
      if (dig_r[4*g +: 4] >= 4'd5) begin
        dabble[4*g +: 4] = dig_r[4*g +: 4] + 4'd3;
      end else begin
        dabble[4*g +: 4] = dig_r[4*g +: 4];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    op_nxt        = op_r;
    alt_nxt       = alt_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_op;
          alt_nxt  = in_tuser[4];
          zero_nxt = (in_val == '0);
          rem_nxt  = REM_W'(NDIG);
          bin_nxt  = in_val;
          cnt_nxt  = CNT_W'(DATA_WIDTH);
          if (in_op == i2a_pkg::RADIX_DEC) begin
            dig_nxt   = '0;
            state_nxt = ST_CONV;
          end else begin
            dig_nxt   = load_dig;
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        dig_nxt = {dabble[DIG_W-2:0], bin_r[DATA_WIDTH-1]};
        bin_nxt = {bin_r[DATA_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keeping at least one digit.
        if (top_dig == 4'd0 && rem_r != REM_W'(1)) begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          rem_nxt = rem_r - REM_W'(1);
        end else if (has_prefix) begin
          state_nxt = ST_PRE0;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_PRE0: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = i2a_pkg::CH_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = (op_r == i2a_pkg::RADIX_OCT) ? ST_EMIT : ST_PRE1;
        end
      end
      ST_PRE1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (op_r == i2a_pkg::RADIX_HXU) ? i2a_pkg::CH_UPPER_X
                                                       : i2a_pkg::CH_LOWER_X;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = i2a_pkg::digit_char(top_dig, op_r == i2a_pkg::RADIX_HXU);
          out_last_nxt  = (rem_r == REM_W'(1));
          dig_nxt       = {dig_r[DIG_W-5:0], 4'd0};
          rem_nxt       = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    dig_r      <= dig_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    op_r       <= op_nxt;
    alt_r      <= alt_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
